### rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, types and the rotate function of the digest unit.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    // one step request to the round unit
    typedef struct packed {
        logic start;   // load working vars from hash
        logic step;    // do one round
        logic fold;    // add working vars into hash
        logic init;    // restore initial hash
    } core_ctl_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

### rtl/sha256_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// 16-word sliding window; gives W[t] and advances one word per round.
// ----------------------------------------------------------------------------
module sha256_sched
(
    input  logic                clk,
    input  logic                load,      // shift in a block word
    input  sha256_pkg::word_t   load_word,
    input  logic                advance,   // one round consumed
    output sha256_pkg::word_t   w_cur
);
    import sha256_pkg::*;

    word_t win_reg [16];
    word_t win_next [16];
    word_t s0;
    word_t s1;
    word_t w_new;

    assign s0    = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
    assign s1    = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
    assign w_new = s1 + win_reg[9] + s0 + win_reg[0];
    assign w_cur = win_reg[0];

    always_comb
    begin
        win_next = win_reg;
        if (load || advance)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[15] = load ? load_word : w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

### rtl/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One shared compression round per cycle while step is asserted, plus hash state and feed-forward.
// ----------------------------------------------------------------------------
module sha256_round
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha256_pkg::core_ctl_t ctl,
    input  logic [5:0]           round_idx,
    input  sha256_pkg::word_t    w_cur,
    input  logic [2:0]           rd_idx,
    output sha256_pkg::word_t    rd_word
);
    import sha256_pkg::*;

    word_t hash_reg [8];
    word_t hash_next [8];
    word_t v_reg [8];
    word_t v_next [8];
    word_t t1;
    word_t t2;

    assign t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[round_idx] + w_cur;
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign rd_word = hash_reg[rd_idx];

    always_comb
    begin
        v_next    = v_reg;
        hash_next = hash_reg;
        if (ctl.start)
        begin
            v_next = hash_reg;
        end
        else if (ctl.step)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
        if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + v_reg[i];
            end
        end
        else if (ctl.init)
        begin
            hash_next = INIT_HASH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= INIT_HASH;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

endmodule

### rtl/sha256_message_digest_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest unit
// Byte-stream SHA-256 engine with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                 | tuser / tlast
// s_axis  | in  | [7:0] data_byte       | tuser = byte_present, tlast = end_of_message
// m_axis  | out | [31:0] digest_word    | tuser = word_index, tlast = last_word
//
// A byte that completes a 64-byte block holds the input through 16 schedule
// loads, 64 rounds and the feed-forward, all on the single shared round
// unit. End of message sweeps the pad bytes from the fill after the last
// byte to the end of the block, then compresses; a marker at byte 56..63,
// or a last byte that fills its block, adds one more sweep and block. Then
// eight output items. Reset clears hash, count and control; the block
// buffer is not cleared. A stalled output holds its item; no input is taken
// until the digest is fully delivered.
// ----------------------------------------------------------------------------
module sha256_message_digest_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    import sha256_pkg::*;

    state_t      state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [6:0]  cyc_reg, cyc_next;      // 0..15 load, 16..79 rounds
    logic        fin_reg, fin_next;      // finishing the message
    logic        second_reg, second_next; // length block still to go
    logic        padded_reg, padded_next; // block in flight is a padded one
    logic [2:0]  oidx_reg, oidx_next;
    word_t       buf_mem [16];           // block bytes, big-endian words
    word_t       buf_rd_reg;
    logic [5:0]  pad_idx_reg, pad_idx_next;
    logic [5:0]  fill;
    logic [5:0]  fill_after;
    core_ctl_t   ctl;
    logic        in_fire;
    logic        out_fire;
    logic        sched_load;
    logic        sched_adv;
    word_t       w_cur;
    word_t       load_word;
    word_t       hword;
    logic [5:0]  round_idx;
    logic [63:0] bit_len;
    logic [3:0]  lw;

    assign fill       = count_reg[5:0];
    assign fill_after = s_axis_tuser ? 6'(fill + 6'd1) : fill;
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_fire   = m_axis_tvalid && m_axis_tready;
    assign bit_len    = {count_reg, 3'b000};
    assign lw         = cyc_reg[3:0];
    assign round_idx  = 6'(cyc_reg - 7'd16);

    // block word for schedule load; length words overlay bytes 56..63
    always_comb
    begin
        load_word = buf_rd_reg;
        if (padded_reg && !second_reg && lw == 4'd14)
        begin
            load_word = bit_len[63:32];
        end
        else if (padded_reg && !second_reg && lw == 4'd15)
        begin
            load_word = bit_len[31:0];
        end
    end

    // byte buffer: stream writes and padding sweep; word read registered at cyc_next
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire && s_axis_tuser)
        begin
            buf_mem[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= s_axis_tdata;
        end
        else if (state_reg == ST_PAD)
        begin
            // in the length-only block the marker lands under the length words
            buf_mem[pad_idx_reg[5:2]][{~pad_idx_reg[1:0], 3'b000} +: 8] <=
                (pad_idx_reg == fill) ? 8'h80 : 8'h00;
        end
        buf_rd_reg <= buf_mem[cyc_next[3:0]];
    end

    sha256_sched u_sched
    (
        .clk       (clk),
        .load      (sched_load),
        .load_word (load_word),
        .advance   (sched_adv),
        .w_cur     (w_cur)
    );

    sha256_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .round_idx (round_idx),
        .w_cur     (w_cur),
        .rd_idx    (oidx_reg),
        .rd_word   (hword)
    );

    // next state
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        cyc_next     = cyc_reg;
        fin_next     = fin_reg;
        second_next  = second_reg;
        padded_next  = padded_reg;
        oidx_next    = oidx_reg;
        pad_idx_next = pad_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser)
                    begin
                        count_next = count_reg + 61'd1;
                    end
                    cyc_next = '0;
                    if (s_axis_tlast)
                    begin
                        fin_next     = 1'b1;
                        state_next   = ST_PAD;
                        // pad sweep starts at the fill after this byte
                        pad_idx_next = fill_after;
                        second_next  = (fill_after >= 6'd56);
                        if (s_axis_tuser && fill == 6'd63)
                        begin
                            // full block first, then pad a fresh block
                            state_next = ST_ROUND;
                        end
                    end
                    else if (s_axis_tuser && fill == 6'd63)
                    begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_PAD:
            begin
                pad_idx_next = pad_idx_reg + 6'd1;
                if (pad_idx_reg == 6'd63)
                begin
                    state_next  = ST_ROUND;
                    cyc_next    = '0;
                    padded_next = 1'b1;
                end
            end
            ST_ROUND:
            begin
                cyc_next = cyc_reg + 7'd1;
                if (cyc_reg == 7'd79)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                padded_next = 1'b0;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!padded_reg || second_reg)
                begin
                    // data block or marker block w/o length: pad one more
                    state_next   = ST_PAD;
                    second_next  = 1'b0;
                    pad_idx_next = '0;
                end
                else
                begin
                    state_next = ST_EMIT;
                    oidx_next  = '0;
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                        fin_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs / control
    always_comb
    begin
        ctl        = '0;
        sched_load = 1'b0;
        sched_adv  = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_ROUND:
            begin
                if (cyc_reg < 7'd16)
                begin
                    sched_load = 1'b1;
                    ctl.start  = (cyc_reg == 7'd15);
                end
                else
                begin
                    ctl.step  = 1'b1;
                    sched_adv = 1'b1;
                end
            end
            ST_ADD:
            begin
                ctl.fold = 1'b1;
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                ctl.init      = out_fire && (oidx_reg == 3'd7);
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tdata = hword;
    assign m_axis_tuser = oidx_reg;
    assign m_axis_tlast = (oidx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cyc_reg     <= '0;
            fin_reg     <= 1'b0;
            second_reg  <= 1'b0;
            padded_reg  <= 1'b0;
            oidx_reg    <= '0;
            pad_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cyc_reg     <= cyc_next;
            fin_reg     <= fin_next;
            second_reg  <= second_next;
            padded_reg  <= padded_next;
            oidx_reg    <= oidx_next;
            pad_idx_reg <= pad_idx_next;
        end
    end

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input ready while busy");

    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (state_reg == ST_EMIT))
        else $error("output valid outside emit");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(oidx_reg))
        else $error("output index moved while stalled");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_axis_tlast) |=> (state_reg == ST_IDLE && count_reg == '0))
        else $error("digest end did not return to idle");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest unit testbench
// Streams byte items with random gaps into the unit, hashes each message
// in a local SHA-256 model and checks every digest word item in order.
// ----------------------------------------------------------------------------
module testbench;
    import sha256_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic s_axis_tuser = 1'b0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic m_axis_tlast;

    sha256_message_digest_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // model state
    word_t       mdl_hash [8];
    logic [7:0]  mdl_block [64];
    logic [60:0] mdl_count;

    byte_item_t   pending_bytes [$];
    digest_item_t digest_fifo [$];
    int  errors = 0;
    int  cycles = 0;
    bit  stim_done = 0;
    bit  in_taken = 0;   // input item accepted at the last rising edge
    int  hold_off = 0;   // long receiver stall, counted in cycles

    function automatic word_t ror(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic model_reset();
        for (int i = 0; i < 8; i++) mdl_hash[i] = INIT_HASH[i];
        for (int i = 0; i < 64; i++) mdl_block[i] = 8'h00;
        mdl_count = '0;
    endtask

    task automatic compress();
        word_t w [64];
        word_t v [8];
        word_t t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {mdl_block[4*i], mdl_block[4*i+1], mdl_block[4*i+2], mdl_block[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = mdl_hash[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) mdl_hash[i] += v[i];
    endtask

    // absorb one accepted item; queue digest words on end of message
    task automatic hash_absorb(byte_item_t it);
        int fill;
        logic [63:0] bits;
        if (it.byte_present)
        begin
            fill = mdl_count[5:0];
            mdl_block[fill] = it.data_byte;
            mdl_count = mdl_count + 1'b1;
            if (fill == 63) compress();
        end
        if (it.end_of_message)
        begin
            fill = mdl_count[5:0];
            mdl_block[fill] = 8'h80;
            for (int i = fill + 1; i < 64; i++) mdl_block[i] = 8'h00;
            if (fill >= 56)
            begin
                compress();
                for (int i = 0; i < 56; i++) mdl_block[i] = 8'h00;
            end
            bits = {mdl_count, 3'b000};
            for (int i = 0; i < 8; i++) mdl_block[56+i] = bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++)
                digest_fifo.push_back('{mdl_hash[i], 3'(i), i == 7});
            model_reset();
        end
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    task automatic push_msg(int len, bit with_empties);
        byte_item_t it;
        for (int i = 0; i < len; i++)
        begin
            if (with_empties && $urandom_range(0, 7) == 0)
                pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
            it = '{8'($urandom), 1'b1, 1'b0};
            if (i == len - 1 && $urandom_range(0, 1)) it.end_of_message = 1'b1;
            pending_bytes.push_back(it);
        end
        if (len == 0 || !pending_bytes[$].end_of_message)
            pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // stimulus: directed then random messages
    initial
    begin
        model_reset();
        rst_n = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // empty message, empty-item only, extreme bytes
        pending_bytes.push_back('{8'h5a, 1'b0, 1'b0});
        pending_bytes.push_back('{8'hff, 1'b0, 1'b1});
        pending_bytes.push_back('{8'h00, 1'b1, 1'b0});
        pending_bytes.push_back('{8'hff, 1'b1, 1'b1});
        pending_bytes.push_back('{8'h80, 1'b1, 1'b0});
        pending_bytes.push_back('{8'h7f, 1'b0, 1'b0});
        pending_bytes.push_back('{8'h01, 1'b0, 1'b1});
        // block-boundary lengths: second padding block and exact block
        push_msg(56, 0);
        push_msg(64, 0);
        for (int m = 0; m < 4; m++)
            push_msg($urandom_range(0, 12), 1);
        wait (pending_bytes.size() == 0);
        stim_done = 1;
    end

    // driver
    int tx_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                // item taken at the last rising edge
                tx_gap <= gap_len();
                if (pending_bytes.size() > 0 && gap_len() == 0)
                begin
                    {s_axis_tdata, s_axis_tuser, s_axis_tlast} <= pending_bytes[0];
                end
                else
                    s_axis_tvalid <= 0;
            end
            else if (!s_axis_tvalid)
            begin
                if (tx_gap > 0)
                    tx_gap <= tx_gap - 1;
                else if (pending_bytes.size() > 0)
                begin
                    {s_axis_tdata, s_axis_tuser, s_axis_tlast} <= pending_bytes[0];
                    s_axis_tvalid <= 1;
                end
            end
        end
    end

    // monitor on the input side: model sees exactly what was taken
    always @(posedge clk)
    begin
        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            hash_absorb(pending_bytes.pop_front());
        end
    end

    // receiver ready, with one long hold-off early on
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 0;
        else if (cycles == 300)
            hold_off <= 400;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b0
                             : ($urandom_range(0, 19) == 0 ? 1'b0 : 1'b1);
    end

    // output checker
    always @(posedge clk)
    begin
        digest_item_t got, want;
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
            if (digest_fifo.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected digest item, expected none, actual %h", $time, got);
            end
            else
            begin
                want = digest_fifo.pop_front();
                if (got.digest_word !== want.digest_word)
                begin
                    errors++;
                    $display("%0t: digest_word expected %h actual %h", $time,
                             want.digest_word, got.digest_word);
                end
                if (got.word_index !== want.word_index)
                begin
                    errors++;
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             want.word_index, got.word_index);
                end
                if (got.last_word !== want.last_word)
                begin
                    errors++;
                    $display("%0t: last_word expected %b actual %b", $time,
                             want.last_word, got.last_word);
                end
            end
        end
    end

    // end of run and watchdog
    initial
    begin
        fork
            begin
                wait (stim_done && !s_axis_tvalid && digest_fifo.size() == 0);
                repeat (400) @(posedge clk);
            end
            begin
                wait (cycles >= CYCLE_LIMIT);
                $display("timeout: %0d digest items still expected", digest_fifo.size());
                errors++;
            end
        join_any
        if (errors == 0)
            $display("sha256_message_digest_unit verification clean");
        else
            $display("sha256_message_digest_unit verification failed");
        $finish;
    end
endmodule
